// ----- sv/cas_pkg.sv -----
// Shared types and constants of the cave smoothing automaton.
package cas_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GENS   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Width of grid size values; holds both register values and maximum sizes.
    localparam int SIZE_W = 9;

    // A cell becomes wall when more than this many neighbors are walls.
    localparam logic [3:0] WALL_LIMIT = 4'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] col_x;
        logic [5:0] row_y;
        logic       cell_in;
    } t_in_item;

    typedef struct packed {
        logic cell_out;
        logic status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GEN_START,
        ST_GEN_SECOND,
        ST_GEN_ROW
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic cfg_write;
        logic cell_write;
        logic resp_now;
        logic rd_input;
        logic resp_read;
        logic run_init;
        logic rd_row0;
        logic load_first;
        logic row_step;
        logic gen_next;
        logic resp_run;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       out_free;
        logic       run_skip;
        logic       last_row;
        logic       last_gen;
    } t_dp_status;

endpackage

// ----- sv/cave_automaton_smoothing_core.sv -----
// Top level of the cave smoothing automaton.
// The grid is stored as one memory word per row, cleared by per-row valid bits at
// reset, so the block accepts requests right after reset. A cell read passes
// through ST_READ for the registered memory read. In a run command, each
// generation passes ST_GEN_START and ST_GEN_SECOND, which re-prime a three-row
// window from the memory, then ST_GEN_ROW, which updates one whole row per cycle
// through the single write port. A run with zero generations or an empty grid
// answers without entering the generation states. A new request can enter in the
// same cycle that the waiting result is taken; a stalled result stalls the input.
module cave_automaton_smoothing_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cas_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cas_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cas_pkg::t_dp_cmd    w_cmd;
    cas_pkg::t_dp_status w_status;

    cas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_valid (i_cfg_valid)
    );

    cas_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ----- sv/cas_ctrl.sv -----
// Controller state machine of the cave smoothing automaton.
module cas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cas_pkg::t_dp_status i_status,
    output cas_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_cfg_ready,
    input  logic                i_cfg_valid
);

    cas_pkg::t_state r_state;
    cas_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = (r_state == cas_pkg::ST_IDLE) && i_in_valid && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cas_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.func == cas_pkg::FUNC_READ) begin
                        n_state = cas_pkg::ST_READ;
                    end else if (i_status.func == cas_pkg::FUNC_RUN && !i_status.run_skip) begin
                        n_state = cas_pkg::ST_GEN_START;
                    end
                end
            end
            cas_pkg::ST_READ:       n_state = cas_pkg::ST_IDLE;
            cas_pkg::ST_GEN_START:  n_state = cas_pkg::ST_GEN_SECOND;
            cas_pkg::ST_GEN_SECOND: n_state = cas_pkg::ST_GEN_ROW;
            cas_pkg::ST_GEN_ROW: begin
                if (i_status.last_row) begin
                    n_state = i_status.last_gen ? cas_pkg::ST_IDLE : cas_pkg::ST_GEN_START;
                end
            end
            default: n_state = cas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            cas_pkg::ST_IDLE: begin
                o_in_stall      = !i_status.out_free;
                o_cfg_ready     = 1'b1;
                o_cmd.cfg_write = i_cfg_valid;
                o_cmd.accept    = w_accept;
                if (w_accept) begin
                    if (i_status.func == cas_pkg::FUNC_READ) begin
                        o_cmd.rd_input = 1'b1;
                    end else if (i_status.func == cas_pkg::FUNC_RUN) begin
                        o_cmd.run_init = 1'b1;
                        o_cmd.resp_now = i_status.run_skip;
                    end else begin
                        o_cmd.cell_write = (i_status.func == cas_pkg::FUNC_WRITE);
                        o_cmd.resp_now   = 1'b1;
                    end
                end
            end
            cas_pkg::ST_READ:       o_cmd.resp_read  = 1'b1;
            cas_pkg::ST_GEN_START:  o_cmd.rd_row0    = 1'b1;
            cas_pkg::ST_GEN_SECOND: o_cmd.load_first = 1'b1;
            cas_pkg::ST_GEN_ROW: begin
                o_cmd.row_step = 1'b1;
                if (i_status.last_row) begin
                    o_cmd.gen_next = !i_status.last_gen;
                    o_cmd.resp_run = i_status.last_gen;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- sv/cas_dp.sv -----
// Datapath of the cave smoothing automaton: grid memory, row window, config and result.
module cas_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cas_pkg::t_dp_cmd                 i_cmd,
    output cas_pkg::t_dp_status              o_status,
    input  cas_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    output cas_pkg::t_out_item               o_out_data,
    input  logic                             i_out_stall,
    input  logic [cas_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int SW = cas_pkg::SIZE_W;

    // Configuration registers.
    logic [6:0] r_grid_width;
    logic [6:0] r_grid_height;
    logic [7:0] r_generations;

    // Grid memory, one row of cells per word, with a valid bit per row.
    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] r_row_valid;
    logic [MAX_WIDTH-1:0] r_rd_raw;
    logic                 r_rd_vld;
    logic [MAX_WIDTH-1:0] w_rd_row;

    // Generation window and counters.
    logic [MAX_WIDTH-1:0] r_prev;
    logic [MAX_WIDTH-1:0] r_cur;
    logic [YW-1:0]        r_row;
    logic [7:0]           r_gen;

    // Held item for a read.
    logic [XW-1:0] r_x;
    logic          r_oob;

    logic          r_out_valid;
    cas_pkg::t_out_item r_out_data;

    logic [SW-1:0]        w_w_used;
    logic [SW-1:0]        w_h_used;
    logic [MAX_WIDTH-1:0] w_mask;
    logic [MAX_WIDTH-1:0] w_next;
    logic [MAX_WIDTH-1:0] w_new;
    logic [MAX_WIDTH+1:0] w_pe;
    logic [MAX_WIDTH+1:0] w_ce;
    logic [MAX_WIDTH+1:0] w_ne;
    logic                 w_in_oob;
    logic [XW-1:0]        w_in_x;
    logic [YW-1:0]        w_in_y;
    logic [YW-1:0]        w_rd_addr;
    logic [YW-1:0]        w_wr_addr;
    logic                 w_wr_en;
    logic [MAX_WIDTH-1:0] w_wr_data;
    logic [MAX_WIDTH-1:0] w_wr_mask;
    logic                 w_out_take;

    assign w_w_used = ({2'b00, r_grid_width} > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH)
                                                               : {2'b00, r_grid_width};
    assign w_h_used = ({2'b00, r_grid_height} > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT)
                                                                 : {2'b00, r_grid_height};

    assign w_in_oob = ({3'b000, i_in_data.col_x} >= w_w_used) ||
                      ({3'b000, i_in_data.row_y} >= w_h_used);
    assign w_in_x   = XW'(i_in_data.col_x);
    assign w_in_y   = YW'(i_in_data.row_y);

    always_comb begin
        for (int x = 0; x < MAX_WIDTH; x++) begin
            w_mask[x] = SW'(x) < w_w_used;
        end
    end

    assign w_rd_row = r_rd_vld ? r_rd_raw : '0;

    // The row below the current one, with unused columns and rows seen as wall.
    always_comb begin
        if ((SW'(r_row) + SW'(1)) < w_h_used) begin
            w_next = w_rd_row | ~w_mask;
        end else begin
            w_next = '1;
        end
    end

    assign w_pe = {1'b1, r_prev, 1'b1};
    assign w_ce = {1'b1, r_cur, 1'b1};
    assign w_ne = {1'b1, w_next, 1'b1};

    always_comb begin
        logic [3:0] cnt;
        for (int x = 0; x < MAX_WIDTH; x++) begin
            cnt = 4'(w_pe[x]) + 4'(w_pe[x+1]) + 4'(w_pe[x+2]) +
                  4'(w_ce[x]) + 4'(w_ce[x+2]) +
                  4'(w_ne[x]) + 4'(w_ne[x+1]) + 4'(w_ne[x+2]);
            w_new[x] = cnt > cas_pkg::WALL_LIMIT;
        end
    end

    always_comb begin
        if (i_cmd.rd_input) begin
            w_rd_addr = w_in_y;
        end else if (i_cmd.load_first) begin
            w_rd_addr = YW'(1);
        end else if (i_cmd.row_step) begin
            w_rd_addr = r_row + YW'(2);
        end else begin
            w_rd_addr = '0;
        end
    end

    // A row that was never written gets zeros outside the written bits.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_row;
        w_wr_data = '0;
        w_wr_mask = '1;
        if (i_cmd.row_step) begin
            w_wr_en   = 1'b1;
            w_wr_data = w_new & w_mask;
            w_wr_mask = r_row_valid[r_row] ? w_mask : '1;
        end else if (i_cmd.cell_write && !w_in_oob) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_in_y;
            w_wr_data = {{(MAX_WIDTH-1){1'b0}}, i_in_data.cell_in} << w_in_x;
            w_wr_mask = r_row_valid[w_in_y] ? ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << w_in_x) : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            for (int x = 0; x < MAX_WIDTH; x++) begin
                if (w_wr_mask[x]) begin
                    r_mem[w_wr_addr][x] <= w_wr_data[x];
                end
            end
        end
        r_rd_raw <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_row_valid[w_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_row_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
            r_generations <= 8'd1;
        end else if (i_cmd.cfg_write) begin
            case (i_cfg_index)
                cas_pkg::CFG_WIDTH:  r_grid_width  <= i_cfg_data[6:0];
                cas_pkg::CFG_HEIGHT: r_grid_height <= i_cfg_data[6:0];
                cas_pkg::CFG_GENS:   r_generations <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x   <= w_in_x;
            r_oob <= w_in_oob;
        end
        if (i_cmd.run_init) begin
            r_gen <= r_generations;
        end else if (i_cmd.gen_next) begin
            r_gen <= r_gen - 8'd1;
        end
        if (i_cmd.rd_row0) begin
            r_row <= '0;
        end else if (i_cmd.row_step) begin
            r_row <= r_row + YW'(1);
        end
        if (i_cmd.load_first) begin
            r_prev <= '1;
            r_cur  <= w_rd_row | ~w_mask;
        end else if (i_cmd.row_step) begin
            r_prev <= r_cur;
            r_cur  <= w_next;
        end
    end

    assign w_out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_now || i_cmd.resp_read || i_cmd.resp_run) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_now) begin
            r_out_data.cell_out <= 1'b0;
            r_out_data.status   <= w_in_oob && (i_in_data.func == cas_pkg::FUNC_WRITE);
        end else if (i_cmd.resp_read) begin
            r_out_data.cell_out <= !r_oob && w_rd_row[r_x];
            r_out_data.status   <= r_oob;
        end else if (i_cmd.resp_run) begin
            r_out_data <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.func     = i_in_data.func;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.run_skip = (r_generations == 8'd0) || (w_w_used == '0) ||
                               (w_h_used == '0);
    assign o_status.last_row = (SW'(r_row) + SW'(1)) == w_h_used;
    assign o_status.last_gen = r_gen == 8'd1;

endmodule

// ----- bench/cas_tb_pkg.sv -----
// Scoreboard for the cave smoothing automaton: grid tracker and answer checker.
`timescale 1ns / 1ps
package cas_tb_pkg;
    import cas_pkg::*;

    localparam int GRID_W_MAX = 64;
    localparam int GRID_H_MAX = 64;

    class cave_grid_scoreboard;
        bit [GRID_W_MAX*GRID_H_MAX-1:0] cells;
        logic [6:0] width_reg;
        logic [6:0] height_reg;
        logic [7:0] gens_reg;
        t_out_item expected_answers[$];
        int unsigned mismatches;

        function new();
            cells      = '0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            gens_reg   = 8'd1;
            mismatches = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_WIDTH:  width_reg  = data[6:0];
                CFG_HEIGHT: height_reg = data[6:0];
                CFG_GENS:   gens_reg   = data;
                default:    ;
            endcase
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // One generation over the area in use; returns whether any cell changed.
        function bit smooth_once(int span_w, int span_h);
            bit [GRID_W_MAX*GRID_H_MAX-1:0] snap;
            int walls;
            int nx;
            int ny;
            bit next_cell;
            bit changed;
            snap    = cells;
            changed = 1'b0;
            for (int y = 0; y < span_h; y++) begin
                for (int x = 0; x < span_w; x++) begin
                    walls = 0;
                    for (int dy = -1; dy <= 1; dy++) begin
                        for (int dx = -1; dx <= 1; dx++) begin
                            if (dx == 0 && dy == 0) continue;
                            nx = x + dx;
                            ny = y + dy;
                            // Neighbors beyond the area in use count as walls.
                            if (nx < 0 || ny < 0 || nx >= span_w || ny >= span_h) begin
                                walls++;
                            end else if (snap[ny*GRID_W_MAX + nx]) begin
                                walls++;
                            end
                        end
                    end
                    next_cell = (walls > int'(WALL_LIMIT));
                    if (next_cell != cells[y*GRID_W_MAX + x]) changed = 1'b1;
                    cells[y*GRID_W_MAX + x] = next_cell;
                end
            end
            return changed;
        endfunction

        function void note_request(t_in_item req);
            t_out_item ans;
            int span_w;
            int span_h;
            int idx;
            ans    = '0;
            span_w = (width_reg > GRID_W_MAX) ? GRID_W_MAX : int'(width_reg);
            span_h = (height_reg > GRID_H_MAX) ? GRID_H_MAX : int'(height_reg);
            idx    = int'(req.row_y) * GRID_W_MAX + int'(req.col_x);
            case (req.func)
                FUNC_WRITE, FUNC_READ: begin
                    if (req.col_x >= span_w || req.row_y >= span_h) begin
                        ans.status = 1'b1;
                    end else if (req.func == FUNC_WRITE) begin
                        cells[idx] = req.cell_in;
                    end else begin
                        ans.cell_out = cells[idx];
                    end
                end
                FUNC_RUN: begin
                    // Once a generation leaves the grid unchanged, all later ones do too.
                    for (int g = 0; g < int'(gens_reg); g++) begin
                        if (!smooth_once(span_w, span_h)) break;
                    end
                end
                default: ;
            endcase
            expected_answers.push_back(ans);
        endfunction

        function void check_answer(t_out_item got);
            t_out_item want;
            if (expected_answers.size() == 0) begin
                $display("%0t: answer with none expected, cell_out %0d status %0d",
                         $time, got.cell_out, got.status);
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.cell_out !== want.cell_out) begin
                $display("%0t: cell_out mismatch, expected %0d, actual %0d",
                         $time, want.cell_out, got.cell_out);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass
endpackage

// ----- bench/cave_automaton_smoothing_core_tb.sv -----
// Top-level testbench of the cave smoothing automaton core.
`timescale 1ns / 1ps
module cave_automaton_smoothing_core_tb;
    import cas_pkg::*;
    import cas_tb_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam int QUIET_LIMIT   = 100000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cave_grid_scoreboard board;
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    cave_automaton_smoothing_core #(
        .MAX_WIDTH (GRID_W_MAX),
        .MAX_HEIGHT(GRID_H_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99, 0) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_answer(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [1:0] func, int x, int y, bit v);
        t_in_item req;
        req.func    = func;
        req.col_x   = 6'(x);
        req.row_y   = 6'(y);
        req.cell_in = v;
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(req);
    endtask

    task automatic wait_all_answered();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int w, input int h, input int g);
        wait_all_answered();
        write_register(CFG_WIDTH, 8'(w));
        write_register(CFG_HEIGHT, 8'(h));
        write_register(CFG_GENS, 8'(g));
    endtask

    // Mostly cell writes and reads inside the area in use with runs between them;
    // a share of items is raw noise over every field.
    task automatic random_phase(input int count, input int w, input int h, input int g,
                                input int idle_pct, input int stall_pct, input bit long_hold);
        t_in_item req;
        int span_w;
        int span_h;
        int pick;
        set_config(w, h, g);
        span_w             = (w % 128 > GRID_W_MAX) ? GRID_W_MAX : w % 128;
        span_h             = (h % 128 > GRID_H_MAX) ? GRID_H_MAX : h % 128;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (long_hold) hold_request = 1'b1;
        for (int k = 0; k < count; k++) begin
            // Halfway through, the sender waits until every answer is back.
            if (k == count / 2) wait_all_answered();
            pick        = $urandom_range(99, 0);
            req.col_x   = 6'($urandom_range(span_w - 1, 0));
            req.row_y   = 6'($urandom_range(span_h - 1, 0));
            req.cell_in = $urandom_range(1, 0);
            if (pick < 12) begin
                req = t_in_item'($urandom);
            end else if (pick < 52) begin
                req.func = FUNC_WRITE;
            end else if (pick < 60) begin
                req.func = FUNC_RUN;
            end else begin
                req.func = FUNC_READ;
            end
            send_request(req);
        end
    endtask

    initial begin
        board              = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        hold_left          = 0;
        quiet_cycles       = 0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in_data          = '0;
        i_out_stall        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Corners of the full grid, the spare function code and one run.
        send_request(make_item(FUNC_READ, 0, 0, 0));
        send_request(make_item(FUNC_WRITE, 63, 63, 1));
        send_request(make_item(FUNC_READ, 63, 63, 0));
        send_request(make_item(FUNC_WRITE, 0, 0, 1));
        send_request(make_item(FUNC_SPARE, 63, 63, 1));
        send_request(make_item(FUNC_RUN, 0, 0, 0));
        send_request(make_item(FUNC_READ, 0, 0, 0));
        send_request(make_item(FUNC_READ, 32, 32, 0));
        send_request(make_item(FUNC_READ, 63, 63, 0));

        // Small area: coordinates just outside it, and cells kept beyond it.
        set_config(10, 5, 2);
        write_register(CFG_SPARE, 8'hA5);
        send_request(make_item(FUNC_WRITE, 10, 0, 1));
        send_request(make_item(FUNC_READ, 0, 5, 0));
        send_request(make_item(FUNC_WRITE, 9, 4, 1));
        send_request(make_item(FUNC_RUN, 0, 0, 0));
        send_request(make_item(FUNC_READ, 9, 4, 0));
        send_request(make_item(FUNC_READ, 63, 63, 0));

        // Oversized width with zero height leaves no cell in use.
        set_config(255, 0, 1);
        send_request(make_item(FUNC_WRITE, 0, 0, 1));
        send_request(make_item(FUNC_RUN, 0, 0, 0));
        send_request(make_item(FUNC_READ, 0, 0, 0));

        // Zero generations, then the deepest run on the full grid.
        set_config(64, 200, 0);
        send_request(make_item(FUNC_RUN, 0, 0, 0));
        send_request(make_item(FUNC_READ, 63, 63, 0));
        set_config(64, 64, 255);
        send_request(make_item(FUNC_RUN, 0, 0, 0));
        send_request(make_item(FUNC_READ, 17, 40, 0));

        random_phase(230, 64, 64, 1, 0, 0, 1'b0);
        random_phase(250, 12, 9, 3, 73, 0, 1'b0);
        random_phase(200, 1, 40, 2, 0, 73, 1'b0);
        random_phase(250, 37, 64, 4, 14, 14, 1'b1);
        random_phase(120, 64, 2, 255, 0, 73, 1'b0);
        random_phase(100, 20, 20, 0, 14, 14, 1'b0);
        random_phase(150, $urandom_range(64, 3), $urandom_range(64, 3),
                     $urandom_range(6, 1), 73, 0, 1'b0);

        wait_all_answered();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
